// ===== rtl/gtg_pkg.sv =====
package gtg_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    // vector datapath widths
    localparam int XW = 36;   // cordic x / y, signed
    localparam int ZW = 35;   // cordic angle, signed Q4.30
    localparam int EW = 33;   // wrapped heading error, signed Q2.30
    localparam int DW = 34;   // distance, unsigned Q18.16

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [XW-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic [23:0] GAIN_Q24 = 24'd10188013;

    typedef enum logic [2:0] {
        CFG_MAX_LIN  = 3'd0,
        CFG_MAX_ANG  = 3'd1,
        CFG_LIN_GAIN = 3'd2,
        CFG_ANG_GAIN = 3'd3,
        CFG_STOP     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_ARRIVED = 2'd1,
        ST_DRIVING = 2'd2
    } t_status;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            5'd0:  r = 35'sd843314857;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043837;
            5'd3:  r = 35'sd133525159;
            5'd4:  r = 35'sd67021687;
            5'd5:  r = 35'sd33543516;
            5'd6:  r = 35'sd16775851;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194283;
            5'd9:  r = 35'sd2097149;
            5'd31: r = '0;
            default: r = ZW'(36'sd1 <<< (5'd30 - idx));
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/go_to_goal_velocity_controller.sv =====
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | i_valid / o_stall  | i_goal_x/y, i_pose_x/y, i_heading, flags,
//          |                    | i_setpoint
// output   | o_valid / i_stall  | o_linear_cmd, o_angular_cmd, o_status
// config   | i_cfg_we           | i_cfg_addr, i_cfg_data
//
// one transfer per cycle sustained unless the output is stalled; an accepted input
// passes the entry register, one per cordic iteration, m1, m2, m3 and output
// synchronous active-low reset clears stage valids and loads the register defaults
// a stalled output lets upstream stages keep filling bubbles, nothing is lost
module go_to_goal_velocity_controller
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [15:0] i_heading,
    input  logic               i_goal_valid,
    input  logic               i_pose_valid,
    input  logic signed [7:0]  i_setpoint,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [14:0]        o_linear_cmd,
    output logic signed [15:0] o_angular_cmd,
    output logic [1:0]         o_status
);

    localparam int N  = CORDIC_STAGES;
    localparam int NS = N + 5;
    localparam int M1 = N + 1;
    localparam int M2 = N + 2;
    localparam int M3 = N + 3;
    localparam int OS = N + 4;

    logic [14:0] r_max_lin, r_max_ang;
    logic [15:0] r_lin_gain, r_ang_gain;
    logic [30:0] r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lin  <= 15'd1638;
            r_max_ang  <= 15'd4096;
            r_lin_gain <= 16'd2458;
            r_ang_gain <= 16'd8192;
            r_stop     <= 31'd6554;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_LIN:  r_max_lin  <= i_cfg_data[14:0];
                CFG_MAX_ANG:  r_max_ang  <= i_cfg_data[14:0];
                CFG_LIN_GAIN: r_lin_gain <= i_cfg_data[15:0];
                CFG_ANG_GAIN: r_ang_gain <= i_cfg_data[15:0];
                CFG_STOP:     r_stop     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and advance chain
    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_v[OS];

    // entry: difference vector, folded into the right half plane
    logic signed [32:0] dx, dy;
    logic signed [XW-1:0] x0, y0;
    logic signed [ZW-1:0] z0;

    always_comb begin
        dx = 33'(i_goal_x) - 33'(i_pose_x);
        dy = 33'(i_goal_y) - 33'(i_pose_y);
        if (dx < 0) begin
            x0 = -XW'(dx);
            y0 = -XW'(dy);
            z0 = (dy >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
            x0 = XW'(dx);
            y0 = XW'(dy);
            z0 = '0;
        end
    end

    logic signed [XW-1:0] r_cx [0:N];
    logic signed [XW-1:0] r_cy [0:N];
    logic signed [ZW-1:0] r_cz [0:N];
    logic signed [15:0]   r_chd [0:N];
    logic [N:0]           r_czero, r_cidle;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_cx[0]    <= x0;
            r_cy[0]    <= y0;
            r_cz[0]    <= z0;
            r_chd[0]   <= i_heading;
            r_czero[0] <= (dx == 0) && (dy == 0);
            r_cidle[0] <= (i_setpoint < 0) || !i_goal_valid || !i_pose_valid;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cordic
        localparam int SH = (g < 32) ? g : 31;
        logic signed [XW-1:0] xs, ys;
        assign xs = r_cx[g] >>> SH;
        assign ys = r_cy[g] >>> SH;
        always_ff @(posedge i_clk) begin
            if (adv[g+1]) begin
                r_chd[g+1]   <= r_chd[g];
                r_czero[g+1] <= r_czero[g];
                r_cidle[g+1] <= r_cidle[g];
                if (g >= 32 || r_czero[g]) begin
                    r_cx[g+1] <= r_cx[g];
                    r_cy[g+1] <= r_cy[g];
                    r_cz[g+1] <= r_cz[g];
                end else if (r_cy[g] >= 0) begin
                    r_cx[g+1] <= r_cx[g] + ys;
                    r_cy[g+1] <= r_cy[g] - xs;
                    r_cz[g+1] <= r_cz[g] + atan_q30(5'(SH));
                end else begin
                    r_cx[g+1] <= r_cx[g] - ys;
                    r_cy[g+1] <= r_cy[g] + xs;
                    r_cz[g+1] <= r_cz[g] - atan_q30(5'(SH));
                end
            end
        end
    end

    // m1: gain compensation product, heading error wrap
    logic signed [XW-1:0] err_raw, err_w;
    logic [58:0] r_m1_prod;
    logic signed [EW-1:0] r_m1_err;
    logic r_m1_idle;

    always_comb begin
        err_raw = (r_czero[N] ? '0 : XW'(r_cz[N])) - (XW'(r_chd[N]) <<< 17);
        if (err_raw > XW'(PI_Q30)) begin
            err_w = err_raw - TWO_PI_Q30;
        end else if (err_raw < -XW'(PI_Q30)) begin
            err_w = err_raw + TWO_PI_Q30;
        end else begin
            err_w = err_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[M1]) begin
            r_m1_prod <= 59'(r_cx[N][XW-2:0]) * 59'(GAIN_Q24);
            r_m1_err  <= err_w[EW-1:0];
            r_m1_idle <= r_cidle[N];
        end
    end

    // m2: round distance
    logic [58:0] prod_rnd;
    logic [DW-1:0] r_m2_dist;
    logic signed [EW-1:0] r_m2_err;
    logic r_m2_idle;

    assign prod_rnd = r_m1_prod + 59'(24'h800000);

    always_ff @(posedge i_clk) begin
        if (adv[M2]) begin
            r_m2_dist <= prod_rnd[24 +: DW];
            r_m2_err  <= r_m1_err;
            r_m2_idle <= r_m1_idle;
        end
    end

    // m3: arrival test and gain products
    logic [49:0] r_m3_lin;
    logic signed [49:0] r_m3_ang;
    logic r_m3_idle, r_m3_arr;

    always_ff @(posedge i_clk) begin
        if (adv[M3]) begin
            r_m3_lin  <= 50'(r_lin_gain) * 50'(r_m2_dist);
            r_m3_ang  <= 50'($signed({1'b0, r_ang_gain})) * 50'(r_m2_err);
            r_m3_arr  <= r_m2_dist < DW'(r_stop);
            r_m3_idle <= r_m2_idle;
        end
    end

    // output: round, saturate, status
    logic [50:0] lin_rnd;
    logic signed [49:0] ang_rnd;
    logic signed [19:0] ang_q;
    logic signed [19:0] maxa;
    logic [14:0] lin_sat;
    logic signed [15:0] ang_sat;

    always_comb begin
        lin_rnd = 51'(r_m3_lin) + 51'(17'h8000);
        lin_sat = (lin_rnd[50:16] > 35'(r_max_lin)) ? r_max_lin : lin_rnd[30:16];
        ang_rnd = r_m3_ang + 50'sd536870912;
        ang_q   = ang_rnd[49:30];
        maxa    = 20'(r_max_ang);
        if (ang_q > maxa) begin
            ang_sat = maxa[15:0];
        end else if (ang_q < -maxa) begin
            ang_sat = 16'(-maxa);
        end else begin
            ang_sat = ang_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[OS]) begin
            if (r_m3_idle) begin
                o_linear_cmd  <= '0;
                o_angular_cmd <= '0;
                o_status      <= ST_IDLE;
            end else if (r_m3_arr) begin
                o_linear_cmd  <= '0;
                o_angular_cmd <= '0;
                o_status      <= ST_ARRIVED;
            end else begin
                o_linear_cmd  <= lin_sat;
                o_angular_cmd <= ang_sat;
                o_status      <= ST_DRIVING;
            end
        end
    end

endmodule

// ===== tb/sv/go_to_goal_velocity_controller_tb.sv =====
module go_to_goal_velocity_controller_tb;
    import gtg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = CORDIC_STAGES_DEF + 5;
    localparam int N_RANDOM = 930;
    localparam longint MAX_CYCLES = 400000;
    localparam longint PI_Q = 64'sd3373259426;

    typedef struct {
        logic [14:0]        lin;
        logic signed [15:0] ang;
        t_status            st;
    } t_cmd;

    typedef struct {
        logic signed [31:0] gx, gy, px, py;
        logic signed [15:0] hd;
        logic               gv, pv;
        logic signed [7:0]  sp;
    } t_tick;

    class cmd_scoreboard;
        t_cmd   pending_cmds[$];
        int     n_errors;
        longint lim_lin, lim_ang, k_lin, k_ang, stop_dist;

        function void reset_regs();
            lim_lin = 1638;
            lim_ang = 4096;
            k_lin = 2458;
            k_ang = 8192;
            stop_dist = 6554;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [30:0] d);
            case (idx)
                CFG_MAX_LIN:  lim_lin = longint'(d[14:0]);
                CFG_MAX_ANG:  lim_ang = longint'(d[14:0]);
                CFG_LIN_GAIN: k_lin = longint'(d[15:0]);
                CFG_ANG_GAIN: k_ang = longint'(d[15:0]);
                CFG_STOP:     stop_dist = longint'(d);
                default: ;
            endcase
        endfunction

        function longint atan_entry(int i);
            longint tbl[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                                33543516, 16775851, 8388437, 4194283, 2097149};
            if (i < 10) return tbl[i];
            if (i >= 31) return 0;
            return longint'(1) << (30 - i);
        endfunction

        function void note_tick(t_tick t);
            t_cmd   c;
            longint x, y, z, xs, ys, err, ang, lin;
            longint unsigned dist_q;
            c.lin = '0;
            c.ang = '0;
            c.st = ST_IDLE;
            if (t.sp >= 0 && t.gv && t.pv) begin
                x = longint'(t.gx) - longint'(t.px);
                y = longint'(t.gy) - longint'(t.py);
                z = 0;
                if (x < 0) begin
                    z = (y >= 0) ? PI_Q : -PI_Q;
                    x = -x;
                    y = -y;
                end
                if (x == 0 && y == 0) z = 0;
                else begin
                    for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (y >= 0) begin
                            x = x + ys; y = y - xs; z = z + atan_entry(i);
                        end else begin
                            x = x - ys; y = y + xs; z = z - atan_entry(i);
                        end
                    end
                end
                dist_q = (longint'(x) * 10188013 + (longint'(1) << 23)) >> 24;
                if (dist_q < stop_dist) c.st = ST_ARRIVED;
                else begin
                    lin = (k_lin * dist_q + (1 << 15)) >>> 16;
                    if (lin > lim_lin) lin = lim_lin;
                    err = z - longint'(t.hd) * 131072;
                    if (err > PI_Q) err -= 2 * PI_Q;
                    else if (err < -PI_Q) err += 2 * PI_Q;
                    ang = (k_ang * err + (longint'(1) << 29)) >>> 30;
                    if (ang > lim_ang) ang = lim_ang;
                    if (ang < -lim_ang) ang = -lim_ang;
                    c.lin = lin[14:0];
                    c.ang = ang[15:0];
                    c.st = ST_DRIVING;
                end
            end
            pending_cmds.push_back(c);
        endfunction

        function void check_cmd(logic [14:0] lin, logic signed [15:0] ang, logic [1:0] st);
            t_cmd e;
            if (pending_cmds.size() == 0) begin
                $error("command with none pending");
                n_errors++;
                return;
            end
            e = pending_cmds.pop_front();
            if (lin !== e.lin) begin
                $error("linear_cmd exp %0d got %0d", e.lin, lin);
                n_errors++;
            end
            if (ang !== e.ang) begin
                $error("angular_cmd exp %0d got %0d", e.ang, ang);
                n_errors++;
            end
            if (st !== e.st) begin
                $error("status exp %0d got %0d", e.st, st);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_addr = '0;
    logic [30:0]        i_cfg_data = '0;
    logic               i_valid = 0, i_stall = 0;
    logic signed [31:0] i_goal_x = 0, i_goal_y = 0, i_pose_x = 0, i_pose_y = 0;
    logic signed [15:0] i_heading = 0;
    logic               i_goal_valid = 0, i_pose_valid = 0;
    logic signed [7:0]  i_setpoint = 0;
    logic               o_stall, o_valid;
    logic [14:0]        o_linear_cmd;
    logic signed [15:0] o_angular_cmd;
    logic [1:0]         o_status;

    cmd_scoreboard sb = new();
    longint cycles = 0;
    bit hold_off = 0;
    bit feeding_done = 0;

    go_to_goal_velocity_controller dut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    task automatic write_cfg(t_cfg_idx idx, logic [30:0] d);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, d);
    endtask

    task automatic send_tick(t_tick t);
        i_goal_x <= t.gx;
        i_goal_y <= t.gy;
        i_pose_x <= t.px;
        i_pose_y <= t.py;
        i_heading <= t.hd;
        i_goal_valid <= t.gv;
        i_pose_valid <= t.pv;
        i_setpoint <= t.sp;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        sb.note_tick(t);
    endtask

    task automatic send_pause(bit allow_gap);
        int g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic t_tick rand_tick();
        t_tick t;
        t.gx = rand_coord();
        t.gy = rand_coord();
        t.px = rand_coord();
        t.py = rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            t.px = t.gx + $signed($urandom_range(0, 16000)) - 8000;
            t.py = t.gy + $signed($urandom_range(0, 16000)) - 8000;
        end
        t.hd = 16'($signed($urandom_range(0, 51472)) - 25736);
        if ($urandom_range(0, 9) == 0) t.hd = 16'($urandom);
        t.gv = ($urandom_range(0, 9) != 0);
        t.pv = ($urandom_range(0, 9) != 0);
        t.sp = 8'(($urandom_range(0, 7) == 0) ? -$signed({1'b0, 7'($urandom)}) - 1
                                               : 8'($urandom) & 8'h7F);
        return t;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_cmd(o_linear_cmd, o_angular_cmd, o_status);
        if (hold_off) i_stall <= 1;
        else if (feeding_done || $urandom_range(0, 3) != 0) i_stall <= 0;
        else i_stall <= ($urandom_range(0, 9) == 0) || ($urandom_range(0, 1) == 1);
    end

    // long receiver hold-off, counted on its own
    initial begin
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1;
        repeat (120) @(posedge i_clk);
        hold_off = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_tick t;
        sb.reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, flags, idle setpoint, zero vector, heading wrap
        for (int k = 0; k < 20; k++) begin
            t = '{gx: 0, gy: 0, px: 0, py: 0, hd: 0, gv: 1, pv: 1, sp: 0};
            case (k)
                0: ;
                1: begin t.gx = 32'sh7FFF_FFFF; t.px = 32'sh8000_0000; end
                2: begin t.gx = 32'sh8000_0000; t.px = 32'sh7FFF_FFFF; t.gy = -1; end
                3: begin t.gy = 32'sh7FFF_FFFF; t.py = 32'sh8000_0000; end
                4: begin t.gy = 32'sh8000_0000; t.py = 32'sh7FFF_FFFF; end
                5: begin t.gx = -(5 << 16); t.gy = 0; t.hd = 16'sd25736; end
                6: begin t.gx = -(5 << 16); t.gy = -1; t.hd = -16'sd25736; end
                7: begin t.gx = 1 << 16; t.hd = 16'sh7FFF; end
                8: begin t.gx = -(1 << 16); t.gy = 3; t.hd = 16'sh8000; end
                9: begin t.gx = 3 << 16; t.gv = 0; end
                10: begin t.gx = 3 << 16; t.pv = 0; end
                11: begin t.gx = 3 << 16; t.sp = -8'sd1; end
                12: begin t.gx = 3 << 16; t.sp = 8'sh80; end
                13: begin t.gx = 3 << 16; t.sp = 8'sh7F; end
                14: t.gx = 6553;
                15: t.gx = 6554;
                16: begin t.gx = 32'sh7FFF_FFFF; t.gy = 32'sh7FFF_FFFF; t.px = 32'sh8000_0000; t.py = 32'sh8000_0000; end
                17: begin t.gx = 0; t.gy = -(2 << 16); t.hd = 16'sd12868; end
                18: begin t.gx = 2 << 16; t.gy = 2 << 16; t.hd = -16'sd20000; end
                default: begin t.gv = 0; t.pv = 0; t.sp = 8'sh80; end
            endcase
            send_tick(t);
        end
        drain();

        // zero vector with stop distance cleared, then extreme registers
        write_cfg(CFG_STOP, 31'd0);
        t = '{gx: 5, gy: 7, px: 5, py: 7, hd: 16'sd1000, gv: 1, pv: 1, sp: 1};
        send_tick(t);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_MAX_LIN, 31'h7FFF);
                    write_cfg(CFG_MAX_ANG, 31'h7FFF);
                    write_cfg(CFG_LIN_GAIN, 31'hFFFF);
                    write_cfg(CFG_ANG_GAIN, 31'hFFFF);
                    write_cfg(CFG_STOP, 31'd0);
                end
                1: begin
                    write_cfg(CFG_MAX_LIN, 31'd0);
                    write_cfg(CFG_MAX_ANG, 31'd0);
                    write_cfg(CFG_LIN_GAIN, 31'd0);
                    write_cfg(CFG_ANG_GAIN, 31'd0);
                    write_cfg(CFG_STOP, 31'h7FFF_FFFF);
                end
                2: begin
                    write_cfg(CFG_MAX_LIN, 31'($urandom));
                    write_cfg(CFG_MAX_ANG, 31'($urandom));
                    write_cfg(CFG_LIN_GAIN, 31'($urandom));
                    write_cfg(CFG_ANG_GAIN, 31'($urandom));
                    write_cfg(CFG_STOP, 31'($urandom_range(0, 1 << 18)));
                end
                3: begin
                    write_cfg(CFG_MAX_LIN, 31'd1638);
                    write_cfg(CFG_MAX_ANG, 31'd4096);
                    write_cfg(CFG_LIN_GAIN, 31'd2458);
                    write_cfg(CFG_ANG_GAIN, 31'd8192);
                    write_cfg(CFG_STOP, 31'd6554);
                    write_cfg(t_cfg_idx'(3'd7), 31'h1234);
                end
                default: begin
                    write_cfg(CFG_MAX_LIN, 31'($urandom));
                    write_cfg(CFG_MAX_ANG, 31'($urandom));
                    write_cfg(CFG_LIN_GAIN, 31'($urandom));
                    write_cfg(CFG_ANG_GAIN, 31'($urandom));
                    write_cfg(CFG_STOP, 31'($urandom));
                end
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                send_tick(rand_tick());
                // no gaps during the long hold-off or the first 21 ticks of each hundred, so the pipe backs up
                send_pause(!hold_off && (n % 100) > 20);
            end
            drain();
        end

        feeding_done = 1;
        if (sb.n_errors == 0 && sb.pending_cmds.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
